>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthands for clocked concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the synchronous reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Widths, register indexes, event codes and reset values shared by the block.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int TIME_W      = 32;
    localparam int MS_W        = 16;
    localparam int EVENT_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = MS_W;
    localparam int IN_TDATA_W  = ((1 + TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((EVENT_W + 7) / 8) * 8;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT   = 2'd0,
        CFG_LONG      = 2'd1,
        CFG_VERY_LONG = 2'd2,
        CFG_WINDOW    = 2'd3
    } t_cfg_idx;

    // Event codes reported for each poll.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_SINGLE    = 3'd1,
        EV_DOUBLE    = 3'd2,
        EV_LONG      = 3'd3,
        EV_VERY_LONG = 3'd4
    } t_event;

    // Configuration register file as seen by the classifier.
    typedef struct packed {
        logic            present;
        logic [MS_W-1:0] long_ms;
        logic [MS_W-1:0] very_long_ms;
        logic [MS_W-1:0] window_ms;
    } t_cfg;

    localparam logic [MS_W-1:0] LONG_MS_RST      = 16'd3000;
    localparam logic [MS_W-1:0] VERY_LONG_MS_RST = 16'd8000;
    localparam logic [MS_W-1:0] WINDOW_MS_RST    = 16'd300;

endpackage

>>> rtl/bgc_core.sv
// ----------------------------------------------------------------------------
// Button gesture classifier core
// Gesture state machine; classifies one poll per load and registers the event.
// ----------------------------------------------------------------------------
module bgc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bgc_pkg::t_cfg              i_cfg,
    input  logic                       i_load,
    input  logic                       i_down,
    input  logic [bgc_pkg::TIME_W-1:0] i_time,
    output bgc_pkg::t_event            o_event
);
    import bgc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_HELD = 2'd1,
        S_WAIT = 2'd2
    } t_mode;

    t_mode               r_mode,         n_mode;
    logic [TIME_W-1:0]   r_press_time,   n_press_time;
    logic [TIME_W-1:0]   r_release_time, n_release_time;
    logic                r_long_done,    n_long_done;
    logic                r_vlong_done,   n_vlong_done;
    t_event              r_event,        n_event;

    logic [TIME_W-1:0]   since_press;
    logic [TIME_W-1:0]   since_release;
    logic                long_due;
    logic                vlong_due;
    logic                window_over;

    // Elapsed times wrap modulo 2^32.
    assign since_press   = i_time - r_press_time;
    assign since_release = i_time - r_release_time;
    assign long_due      = since_press   >= {{(TIME_W-MS_W){1'b0}}, i_cfg.long_ms};
    assign vlong_due     = since_press   >= {{(TIME_W-MS_W){1'b0}}, i_cfg.very_long_ms};
    assign window_over   = since_release >= {{(TIME_W-MS_W){1'b0}}, i_cfg.window_ms};

    always_comb begin
        n_mode         = r_mode;
        n_press_time   = r_press_time;
        n_release_time = r_release_time;
        n_long_done    = r_long_done;
        n_vlong_done   = r_vlong_done;
        n_event        = EV_NONE;
        if (i_cfg.present) begin
            unique case (r_mode)
                S_HELD: begin
                    if (!i_down) begin
                        if (!long_due) begin
                            n_mode         = S_WAIT;
                            n_release_time = i_time;
                        end else begin
                            n_mode = S_IDLE;
                        end
                    end else if (vlong_due && !r_vlong_done) begin
                        // Very long is checked first; a long press due now waits a poll.
                        n_vlong_done = 1'b1;
                        n_event      = EV_VERY_LONG;
                    end else if (long_due && !r_long_done) begin
                        n_long_done = 1'b1;
                        n_event     = EV_LONG;
                    end
                end
                S_WAIT: begin
                    if (i_down && !window_over) begin
                        n_mode  = S_IDLE;
                        n_event = EV_DOUBLE;
                    end else if (window_over) begin
                        n_mode  = S_IDLE;
                        n_event = EV_SINGLE;
                    end
                end
                default: begin
                    if (i_down) begin
                        n_mode       = S_HELD;
                        n_press_time = i_time;
                        n_long_done  = 1'b0;
                        n_vlong_done = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= S_IDLE;
            r_press_time   <= '0;
            r_release_time <= '0;
            r_long_done    <= 1'b0;
            r_vlong_done   <= 1'b0;
            r_event        <= EV_NONE;
        end else if (i_load) begin
            r_mode         <= n_mode;
            r_press_time   <= n_press_time;
            r_release_time <= n_release_time;
            r_long_done    <= n_long_done;
            r_vlong_done   <= n_vlong_done;
            r_event        <= n_event;
        end
    end

    assign o_event = r_event;

endmodule

>>> rtl/button_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// Button gesture classifier
// Turns polls of an active-low push button into click, double click, long
// press and very long press events, one event word per poll word.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)         Per word
//  --------  ---------  ---------------------------------  --------------------
//  s_axis    in         pin_level[0], time_ms[32:1]        one poll
//  m_axis    out        event_res[2:0]                     one event (may be 0)
//  cfg       in         index 0..3, data[15:0]             one register write
//
// Each poll word is classified in the cycle it is accepted and its event is
// in the output register on the next cycle, so a new poll is accepted every
// cycle while the output side keeps taking words.
// The throughput limit is the single output register: s_axis_tready is high
// whenever that register is empty or is being drained in the same cycle.
// A stalled output word holds its value; the poll side then waits.
// Reset is synchronous and active low. It returns the state machine to idle,
// clears the timestamps and fired marks, and loads the register defaults
// (button absent, 3000 ms long press, 8000 ms very long press, 300 ms window).
//
module button_gesture_classifier_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Poll words.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pin_level [0], time_ms [32:1], zero fill [39:33]
    input  logic [bgc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Event words.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: event_res [2:0], zero fill [7:3]
    output logic [bgc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import bgc_pkg::*;

    t_cfg   r_cfg;
    logic   r_out_valid;
    logic   poll_accept;
    t_event core_event;

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.present      <= 1'b0;
            r_cfg.long_ms      <= LONG_MS_RST;
            r_cfg.very_long_ms <= VERY_LONG_MS_RST;
            r_cfg.window_ms    <= WINDOW_MS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRESENT:   r_cfg.present      <= i_cfg_data[0];
                CFG_LONG:      r_cfg.long_ms      <= i_cfg_data;
                CFG_VERY_LONG: r_cfg.very_long_ms <= i_cfg_data;
                CFG_WINDOW:    r_cfg.window_ms    <= i_cfg_data;
                default:       r_cfg              <= r_cfg;
            endcase
        end
    end

    // The output register is free when empty or when its word leaves now.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign poll_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (poll_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The pin is active low: a zero level means the button is down.
    bgc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_load  (poll_accept),
        .i_down  (!s_axis_tdata[0]),
        .i_time  (s_axis_tdata[TIME_W:1]),
        .o_event (core_event)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-EVENT_W){1'b0}}, core_event};

endmodule

>>> rtl/bgc_checker.sv
// ----------------------------------------------------------------------------
// Button gesture classifier checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bgc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bgc_pkg::*;

    // A stalled event word keeps its value.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled event word changed")

    // Every accepted poll produces an event word on the next cycle.
    `ASSERT_CLK_RST(a_poll_gives_event, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "accepted poll gave no event word")

    // With the output register empty the poll side is never held off.
    `ASSERT_CLK_RST(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "poll side stalled with empty output")

    // Only defined event codes leave the block, with the fill bits at zero.
    `ASSERT_CLK_RST(a_event_code, i_clk, i_rst_n, m_axis_tvalid |-> ((m_axis_tdata[EVENT_W-1:0] <= EV_VERY_LONG) && (m_axis_tdata[OUT_TDATA_W-1:EVENT_W] == '0)), "undefined event code")

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
